[src/msr_pkg.sv]
`timescale 1ns / 1ps

package msr_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_BITS_DEF  = 16;
    localparam int MID_W        = 16;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_CONTAINS = 2'd2,
        REQ_REPR     = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t        req_type;
        logic [MID_W-1:0] member_id;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic [MID_W-1:0]     first_member;
        logic [CNT_OUT_W-1:0] count_after;
        status_t              status;
    } rsp_t;

endpackage

[src/msr_cell.sv]
`timescale 1ns / 1ps

module msr_cell #(
    parameter int W = msr_pkg::ID_BITS_DEF
) (
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    import msr_pkg::*;

    logic [W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

[src/msr_ctrl.sv]
`timescale 1ns / 1ps

module msr_ctrl #(
    parameter int CAPACITY = msr_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = msr_pkg::ID_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  msr_pkg::req_t      req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output msr_pkg::rsp_t      rsp,
    input  logic [ID_BITS-1:0] head,
    output logic               shift_en,
    output logic [ID_BITS-1:0] tail_data
);
    import msr_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg,     state_next;
    logic [SW-1:0]      step_reg,      step_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic [ID_BITS-1:0] last_reg,      last_next;
    logic [ID_BITS-1:0] cap_reg,       cap_next;
    logic [ID_BITS-1:0] key_reg,       key_next;
    req_kind_t          kind_reg,      kind_next;
    logic               found_reg,     found_next;
    logic               wrote_reg,     wrote_next;
    rsp_t               res_reg,       res_next;
    rsp_t               rsp_reg,       rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               in_scan;
    logic [CW-1:0]      step_c;
    logic               in_range;
    logic               hit;
    logic               add_write;
    logic               take_tail;
    logic               last_step;
    logic [31:0]        id32;
    logic [ID_BITS-1:0] key_in;
    logic [31:0]        head32;
    logic [CW-1:0]      cnt_fin;
    logic [31:0]        cnt_fin32;
    logic [31:0]        cnt_cur32;

    assign id32      = 32'(req.member_id);
    assign key_in    = id32[ID_BITS-1:0];
    assign head32    = 32'(head);
    assign cnt_cur32 = 32'(count_reg);

    assign in_scan  = (state_reg == S_SCAN);
    assign step_c   = CW'(step_reg);
    assign in_range = (step_c < count_reg);
    assign hit      = in_scan && in_range && (head == key_reg);
    // slot just past the members comes by the head once the dup search is over
    assign add_write = in_scan && (kind_reg == REQ_ADD) && !found_reg
                       && (step_c == count_reg);
    // tail word at slot count-2 is the new last member after a remove
    assign take_tail = in_scan
                       && ((CW+1)'(step_reg) + (CW+1)'(2) == (CW+1)'(count_reg));
    assign last_step = (step_reg == SW'(CAPACITY - 1));

    always_comb
    begin
        tail_data = head;
        if (in_scan && (kind_reg == REQ_REMOVE) && hit && !found_reg)
        begin
            tail_data = last_reg;
        end
        else if (add_write)
        begin
            tail_data = key_reg;
        end
    end

    assign shift_en = in_scan;

    always_comb
    begin
        cnt_fin = count_reg;
        if ((kind_reg == REQ_REMOVE) && found_reg)
        begin
            cnt_fin = count_reg - CW'(1);
        end
        else if ((kind_reg == REQ_ADD) && wrote_reg)
        begin
            cnt_fin = count_reg + CW'(1);
        end
    end
    assign cnt_fin32 = 32'(cnt_fin);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        cap_next       = cap_reg;
        key_next       = key_reg;
        kind_next      = kind_reg;
        found_next     = found_reg;
        wrote_next     = wrote_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next   = key_in;
                    kind_next  = req.req_type;
                    found_next = 1'b0;
                    wrote_next = 1'b0;
                    step_next  = '0;
                    if (req.req_type == REQ_REPR)
                    begin
                        res_next.found        = 1'b0;
                        res_next.count_after  = cnt_cur32[CNT_OUT_W-1:0];
                        if (count_reg == '0)
                        begin
                            res_next.first_member = '0;
                            res_next.status       = ST_EMPTY;
                        end
                        else
                        begin
                            res_next.first_member = head32[MID_W-1:0];
                            res_next.status       = ST_OK;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                step_next  = step_reg + SW'(1);
                found_next = found_reg | hit;
                wrote_next = wrote_reg | add_write;
                if (take_tail)
                begin
                    cap_next = tail_data;
                end
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                count_next = cnt_fin;
                if ((kind_reg == REQ_REMOVE) && found_reg)
                begin
                    last_next = cap_reg;
                end
                else if ((kind_reg == REQ_ADD) && wrote_reg)
                begin
                    last_next = key_reg;
                end
                res_next.found        = found_reg && (kind_reg != REQ_ADD);
                res_next.first_member = '0;
                res_next.count_after  = cnt_fin32[CNT_OUT_W-1:0];
                res_next.status       = ST_OK;
                if (kind_reg == REQ_ADD)
                begin
                    if (found_reg)
                    begin
                        res_next.status = ST_DUP;
                    end
                    else if (!wrote_reg)
                    begin
                        res_next.status = ST_FULL;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            wrote_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            wrote_reg     <= wrote_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        cap_reg  <= cap_next;
        key_reg  <= key_next;
        kind_reg <= kind_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/member_set_swap_remove_top.sv]
`timescale 1ns / 1ps
// Add, remove and contains: after accept the controller steps through scan, finish and done;
// the members rotate once around the ring of cells, one slot past the head compare per cycle.
// Representative: the head word is answered without a scan (slot zero sits at the head).
// One word is in flight at a time: the next request is taken only after the result enters the
// output register, and that waits while a finished word waits for the register to drain.
// Reset clears the member count and the handshake state; slot contents are not cleared.
module member_set_swap_remove_top #(
    parameter int CAPACITY = msr_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = msr_pkg::ID_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  msr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output msr_pkg::rsp_t rsp
);
    import msr_pkg::*;

    logic               shift_en;
    logic [ID_BITS-1:0] tail_data;
    logic [ID_BITS-1:0] cell_q [CAPACITY];

    msr_ctrl #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .head      (cell_q[0]),
        .shift_en  (shift_en),
        .tail_data (tail_data)
    );

    // cell i takes cell i+1; the last cell takes the head word back from control, or the word put in its place
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == CAPACITY - 1)
        begin : g_tail
            msr_cell #(.W(ID_BITS)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (tail_data),
                .q        (cell_q[g])
            );
        end
        else
        begin : g_body
            msr_cell #(.W(ID_BITS)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[g+1]),
                .q        (cell_q[g])
            );
        end
    end

endmodule

[src/msr_checker.sv]
`timescale 1ns / 1ps

module msr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input msr_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input msr_pkg::rsp_t rsp
);
    import msr_pkg::*;

    // one word in flight: the block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("input taken again right after accept");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_EMPTY)
            |-> (rsp.count_after == '0 && rsp.first_member == '0 && !rsp.found))
        else $error("empty-set response inconsistent");

    a_add_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_DUP))
            |-> (!rsp.found && rsp.first_member == '0))
        else $error("rejected add carries found or member");

endmodule

bind member_set_swap_remove_top msr_checker u_msr_checker (.*);
